@@ sv/chained_hash_table_top_defines.svh @@
// ----------------------------------------------------------------------------
// Chained hash table assertion macros
// Shared property checks, clocked on clk and held off during rst_n low.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_TOP_DEFINES_SVH
`define CHAINED_HASH_TABLE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chained hash table check failed");

// Consequent must hold in the cycle after the antecedent.
`define CHT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chained hash table check failed");

`endif

@@ sv/cht_pkg.sv @@
// ----------------------------------------------------------------------------
// Chained hash table package
// Geometry, action and status codes, and controller command type.
// ----------------------------------------------------------------------------
package cht_pkg;

    // BUCKETS must be a power of two: the bucket index is the low key bits.
    localparam int BUCKETS = 64;
    localparam int WAYS    = 4;

    localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_FIND   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] value;
    } entry_t;

    typedef entry_t [WAYS-1:0] row_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;    // item accepted: capture fields, read bucket row
        logic finish;  // compare ways, update store, load result register
    } cmd_t;

endpackage

@@ sv/cht_ctrl.sv @@
// ----------------------------------------------------------------------------
// Chained hash table controller
// Two-state sequencer: bucket read, then compare, write-back and result
// register load, with output handshake tracking.
// ----------------------------------------------------------------------------
`include "chained_hash_table_top_defines.svh"

module cht_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output cht_pkg::cmd_t cmd
);

    typedef enum logic
    {
        S_IDLE,
        S_LOOKUP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready   = (state_reg == S_IDLE);
    assign cmd.load   = in_valid && in_ready;
    // Hold the lookup while the previous result has not been taken.
    assign cmd.finish = (state_reg == S_LOOKUP) && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (cmd.finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        priority if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `CHT_ASSERT_NEXT(a_load_enters_lookup, cmd.load, (state_reg == S_LOOKUP) && !in_ready)
    `CHT_ASSERT_NEXT(a_finish_shows_item, cmd.finish, out_valid_reg && (state_reg == S_IDLE))
    `CHT_ASSERT_NEXT(a_stall_holds_lookup, (state_reg == S_LOOKUP) && out_valid_reg && !out_ready, (state_reg == S_LOOKUP) && out_valid_reg)

endmodule

@@ sv/cht_datapath.sv @@
// ----------------------------------------------------------------------------
// Chained hash table datapath
// Bucket row memory, per-entry used flags, way compare, free-way pick,
// write-back and result register.
// ----------------------------------------------------------------------------
`include "chained_hash_table_top_defines.svh"

module cht_datapath
(
    input  logic          clk,
    input  logic          rst_n,
    input  cht_pkg::cmd_t cmd,
    input  logic [1:0]    action,
    input  logic [31:0]   key,
    input  logic [31:0]   value,
    output logic [1:0]    status,
    output logic [31:0]   found_value
);

    cht_pkg::row_t                   bucket_mem [cht_pkg::BUCKETS];
    cht_pkg::row_t                   row_rd_reg;
    logic [cht_pkg::WAYS-1:0]        used_reg [cht_pkg::BUCKETS];

    logic [1:0]                      action_reg;
    logic [31:0]                     key_reg;
    logic [31:0]                     value_reg;
    logic [cht_pkg::BKT_W-1:0]       bkt_reg;
    logic [1:0]                      status_reg;
    logic [31:0]                     found_value_reg;

    logic [cht_pkg::BKT_W-1:0]       in_bkt;
    logic [cht_pkg::WAYS-1:0]        used_row;
    logic [cht_pkg::WAYS-1:0]        hit_vec;
    logic                            hit_any;
    logic                            free_any;
    logic [cht_pkg::WAY_W-1:0]       hit_way;
    logic [cht_pkg::WAY_W-1:0]       free_way;
    logic                            is_insert;
    logic                            do_insert;
    logic                            do_remove;
    logic [1:0]                      status_next;
    logic [31:0]                     found_value_next;
    cht_pkg::row_t                   row_wr;

    // Power-of-two bucket count: the modulo is a mask of the low key bits.
    assign in_bkt   = cht_pkg::BKT_W'(key % 32'(cht_pkg::BUCKETS));
    assign used_row = used_reg[bkt_reg];

    always_comb
    begin
        for (int w = 0; w < cht_pkg::WAYS; w++)
        begin
            hit_vec[w] = used_row[w] && (row_rd_reg[w].key == key_reg);
        end
    end

    // Lowest matching way and lowest free way.
    always_comb
    begin
        hit_way  = '0;
        free_way = '0;
        for (int w = cht_pkg::WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_way = cht_pkg::WAY_W'(w);
            end
            if (!used_row[w])
            begin
                free_way = cht_pkg::WAY_W'(w);
            end
        end
    end

    assign hit_any   = |hit_vec;
    assign free_any  = ~&used_row;
    assign is_insert = (action_reg == cht_pkg::ACT_INSERT);
    assign do_insert = cmd.finish && is_insert && !hit_any && free_any;
    assign do_remove = cmd.finish && (action_reg == cht_pkg::ACT_REMOVE) && hit_any;

    always_comb
    begin
        found_value_next = '0;
        priority if (is_insert)
        begin
            priority if (hit_any)
            begin
                status_next = cht_pkg::ST_DUPLICATE;
            end
            else if (!free_any)
            begin
                status_next = cht_pkg::ST_FULL;
            end
            else
            begin
                status_next = cht_pkg::ST_OK;
            end
        end
        else if (!hit_any)
        begin
            status_next = cht_pkg::ST_NOT_FOUND;
        end
        else
        begin
            // Remove, find, and the unused code all read the stored value.
            status_next      = cht_pkg::ST_OK;
            found_value_next = row_rd_reg[hit_way].value;
        end
    end

    always_comb
    begin
        row_wr                 = row_rd_reg;
        row_wr[free_way].key   = key_reg;
        row_wr[free_way].value = value_reg;
    end

    // Row memory: read on accept, write back on a successful insert.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            row_rd_reg <= bucket_mem[in_bkt];
        end
        if (do_insert)
        begin
            bucket_mem[bkt_reg] <= row_wr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action;
            key_reg    <= key;
            value_reg  <= value;
            bkt_reg    <= in_bkt;
        end
        if (cmd.finish)
        begin
            status_reg      <= status_next;
            found_value_reg <= found_value_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < cht_pkg::BUCKETS; b++)
            begin
                used_reg[b] <= '0;
            end
        end
        else
        begin
            // Insert and remove never fire together.
            if (do_insert)
            begin
                used_reg[bkt_reg][free_way] <= 1'b1;
            end
            else if (do_remove)
            begin
                used_reg[bkt_reg][hit_way] <= 1'b0;
            end
        end
    end

    assign status      = status_reg;
    assign found_value = found_value_reg;

    `CHT_ASSERT_SAME(a_key_unique_in_bucket, cmd.finish, $onehot0(hit_vec))
    `CHT_ASSERT_NEXT(a_insert_marks_used, do_insert, used_reg[$past(bkt_reg)][$past(free_way)])
    `CHT_ASSERT_NEXT(a_remove_frees_entry, do_remove, !used_reg[$past(bkt_reg)][$past(hit_way)])

endmodule

@@ sv/chained_hash_table_top.sv @@
// ----------------------------------------------------------------------------
// Chained hash table top level
// Key-value store: 64 buckets of 4 ways, insert, remove and find.
// ----------------------------------------------------------------------------
// On accept, the whole bucket row (all ways) is read from the synchronous
// row memory; in the lookup state all ways are then compared side by side,
// the row is written back on a successful insert and the result register
// is loaded. A new item is taken only once the current one has left the
// lookup state; a result not yet taken holds the lookup state until the
// result register frees up. Used flags are flip-flops cleared by reset, so
// the store is empty and ready at once after reset, with no clearing pass.
// ----------------------------------------------------------------------------
module chained_hash_table_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [31:0] key,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] found_value
);

    cht_pkg::cmd_t cmd;

    cht_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    cht_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .action      (action),
        .key         (key),
        .value       (value),
        .status      (status),
        .found_value (found_value)
    );

endmodule
